[rtl/wmm_pkg.sv]
// Shared types and constants for the weighted majority matrix block.
// Holds the transaction structs, function codes and the store command format.
// No dependencies.
package wmm_pkg;

   localparam int unsigned NODES_DEFAULT = 64;
   localparam int unsigned ACTIVE_W      = 7;
   localparam int unsigned SLOT_W        = 6;
   localparam int unsigned WEIGHT_W      = 16;
   localparam int unsigned VALUE_W       = 32;
   localparam int unsigned COUNT_W       = 16;
   localparam int unsigned FUNC_W        = 2;

   // Function codes carried in a request
   localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [SLOT_W-1:0]   node_slot;
      logic [SLOT_W-1:0]   col_slot;
      logic [WEIGHT_W-1:0] weight;
      logic                last_in_list;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] entry_value;
      logic [COUNT_W-1:0] lists_seen;
      logic               saturated;
   } rsp_type;

   // Operation performed by the store on one entry
   typedef enum logic [1:0] {
      ACC_READ,
      ACC_ADD,
      ACC_ZERO
   } acc_kind_type;

   typedef struct packed {
      logic                valid;
      acc_kind_type        kind;
      logic                blank;   // read answers zero (row or column out of range)
      logic [WEIGHT_W-1:0] weight;
   } acc_cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0] lists_seen;
      logic               saturated;
   } stat_type;

endpackage

[rtl/wmm_store.sv]
// Preference matrix store: one synchronous memory plus a read-modify-write stage.
// Registered read, then adds with saturation or zeroes and writes back the next cycle.
// Depends on wmm_pkg.
module wmm_store #(
   parameter int unsigned AddrW = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  wmm_pkg::acc_cmd_type      cmd,
   input  logic [AddrW-1:0]          addr,
   output logic [wmm_pkg::VALUE_W-1:0] rd_value,
   output logic                      rd_valid,
   output logic                      sat_hit
);
   import wmm_pkg::*;

   localparam int unsigned MemDepth = 1 << AddrW;

   logic [VALUE_W-1:0] mem [MemDepth];
   logic [VALUE_W-1:0] q_ff;

   acc_cmd_type        cmd_ff;
   logic [AddrW-1:0]   addr_ff;

   logic [VALUE_W:0]   sum;
   logic               wr_en;
   logic [VALUE_W-1:0] wr_data;

   // Memory: registered read, write from the second stage
   always_ff @(posedge clock) begin
      if (cmd.valid) begin
         q_ff <= mem[addr];
      end
      if (wr_en) begin
         mem[addr_ff] <= wr_data;
      end
   end

   // Second-stage command
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff.valid <= 1'b0;
      end else begin
         cmd_ff.valid <= cmd.valid;
      end
      cmd_ff.kind   <= cmd.kind;
      cmd_ff.blank  <= cmd.blank;
      cmd_ff.weight <= cmd.weight;
      addr_ff       <= addr;
   end

   // Saturating accumulate
   always_comb begin
      sum      = {1'b0, q_ff} + {{(VALUE_W + 1 - WEIGHT_W){1'b0}}, cmd_ff.weight};
      wr_en    = 1'b0;
      wr_data  = '0;
      rd_valid = 1'b0;
      sat_hit  = 1'b0;
      case (cmd_ff.kind)
         ACC_ADD: begin
            wr_en   = cmd_ff.valid;
            wr_data = sum[VALUE_W] ? '1 : sum[VALUE_W-1:0];
            sat_hit = cmd_ff.valid && sum[VALUE_W];
         end
         ACC_ZERO: begin
            wr_en = cmd_ff.valid;
         end
         ACC_READ: begin
            rd_valid = cmd_ff.valid;
         end
         default: begin
         end
      endcase
      rd_value = cmd_ff.blank ? '0 : q_ff;
   end

endmodule

[rtl/wmm_ctrl.sv]
// Sequencer for the weighted majority matrix: request decode, walks over rows
// and columns, seen mask, list counter and saturation flag. Depends on wmm_pkg.
module wmm_ctrl #(
   parameter  int unsigned Nodes = 64,
   localparam int unsigned IdxW  = $clog2(Nodes),
   localparam int unsigned CntW  = $clog2(Nodes + 1),
   localparam int unsigned AddrW = 2 * IdxW,
   localparam int unsigned ActW  = (CntW > wmm_pkg::ACTIVE_W) ? CntW : wmm_pkg::ACTIVE_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  wmm_pkg::req_type            req_data,
   output logic                        busy,
   input  logic                        csr_valid,
   input  logic [wmm_pkg::ACTIVE_W-1:0] csr_data,
   output wmm_pkg::acc_cmd_type        cmd,
   output logic [AddrW-1:0]            addr,
   input  logic                        sat_hit,
   output wmm_pkg::stat_type           status
);
   import wmm_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ADD   = 6'b000010,
      ST_END   = 6'b000100,
      ST_SWEEP = 6'b001000,
      ST_READ  = 6'b010000,
      ST_DRAIN = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [ActW-1:0]    active_ff, active_in;
   logic [Nodes-1:0]   seen_ff, seen_in;
   logic [CntW-1:0]    row_ff, row_in;
   logic [CntW-1:0]    col_ff, col_in;
   logic [AddrW-1:0]   sweep_ff, sweep_in;
   logic [COUNT_W-1:0] lists_ff, lists_in;
   logic               sat_ff, sat_in;

   logic [CntW-1:0]    n_active;
   logic [IdxW-1:0]    row_idx, col_idx, node_idx;
   logic               row_last, col_last, in_node_ok;

   // Effective node count, capped at the array size
   always_comb begin
      n_active   = (active_ff > ActW'(Nodes)) ? CntW'(Nodes) : CntW'(active_ff);
      row_idx    = row_ff[IdxW-1:0];
      col_idx    = col_ff[IdxW-1:0];
      node_idx   = IdxW'(req_ff.node_slot);
      row_last   = (row_ff + CntW'(1)) == n_active;
      col_last   = (col_ff + CntW'(1)) == n_active;
      in_node_ok = (32'(req_data.node_slot) < 32'(n_active))
                   && !seen_ff[IdxW'(req_data.node_slot)];
   end

   assign busy   = (state_ff != ST_IDLE);
   assign status = '{lists_seen: lists_ff, saturated: sat_ff};

   // Next state and store commands
   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      active_in  = active_ff;
      seen_in    = seen_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      sweep_in   = sweep_ff;
      lists_in   = lists_ff;
      sat_in     = sat_ff | sat_hit;
      cmd        = '0;
      cmd.kind   = ACC_READ;
      cmd.weight = req_ff.weight;
      addr       = '0;

      if (csr_valid) begin
         active_in = ActW'(csr_data);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               row_in = '0;
               col_in = '0;
               unique case (req_data.func)
                  FUNC_ADD: begin
                     if (in_node_ok) begin
                        state_in = ST_ADD;
                     end else if (req_data.last_in_list) begin
                        state_in = ST_END;
                     end else begin
                        state_in = ST_DRAIN;
                     end
                  end
                  FUNC_READ: begin
                     state_in = ST_READ;
                  end
                  FUNC_CLEAR: begin
                     seen_in  = '0;
                     lists_in = '0;
                     sat_in   = 1'b0;
                     sweep_in = '0;
                     state_in = ST_SWEEP;
                  end
                  default: begin
                     state_in = ST_DRAIN;
                  end
               endcase
            end
         end

         // Earlier nodes of the list each gain the weight over the new node
         ST_ADD: begin
            cmd.valid = seen_ff[row_idx];
            cmd.kind  = ACC_ADD;
            addr      = {row_idx, node_idx};
            row_in    = row_ff + CntW'(1);
            if (row_last) begin
               seen_in[node_idx] = 1'b1;
               row_in            = '0;
               state_in          = req_ff.last_in_list ? ST_END : ST_DRAIN;
            end
         end

         // End of list: present rows gain the weight over absent columns
         ST_END: begin
            if (row_ff >= n_active) begin
               seen_in = '0;
               if (lists_ff != COUNT_MAX) begin
                  lists_in = lists_ff + COUNT_W'(1);
               end else begin
                  sat_in = 1'b1;
               end
               state_in = ST_DRAIN;
            end else if (!seen_ff[row_idx]) begin
               row_in = row_ff + CntW'(1);
            end else begin
               cmd.valid = !seen_ff[col_idx];
               cmd.kind  = ACC_ADD;
               addr      = {row_idx, col_idx};
               col_in    = col_ff + CntW'(1);
               if (col_last) begin
                  col_in = '0;
                  row_in = row_ff + CntW'(1);
               end
            end
         end

         // Clearing pass over the whole memory
         ST_SWEEP: begin
            cmd.valid = 1'b1;
            cmd.kind  = ACC_ZERO;
            addr      = sweep_ff;
            sweep_in  = sweep_ff + AddrW'(1);
            if (&sweep_ff) begin
               state_in = ST_DRAIN;
            end
         end

         ST_READ: begin
            cmd.valid = 1'b1;
            cmd.kind  = ACC_READ;
            cmd.blank = (32'(req_ff.node_slot) >= 32'(Nodes))
                        || (32'(req_ff.col_slot) >= 32'(Nodes));
            addr      = {IdxW'(req_ff.node_slot), IdxW'(req_ff.col_slot)};
            state_in  = ST_DRAIN;
         end

         // Let the write-back stage finish
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_SWEEP;
         active_ff <= ActW'(Nodes);
         seen_ff   <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         sweep_ff  <= '0;
         lists_ff  <= '0;
         sat_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         seen_ff   <= seen_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         sweep_ff  <= sweep_in;
         lists_ff  <= lists_in;
         sat_ff    <= sat_in;
      end
   end

   // Captured request
   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

endmodule

[rtl/weighted_majority_matrix.sv]
// Top level of the weighted majority matrix: sequencer, matrix store, result register.
// Depends on wmm_pkg, wmm_ctrl and wmm_store.
//
// Builds a pairwise preference matrix from weighted ranked lists fed one element at a
// time. A transaction is taken when start is high and busy is low; busy stays high
// until the transaction is fully done. Every matrix update is one read-modify-write of
// the single matrix memory, one entry per cycle: an add element walks over the active
// rows, and an element that ends a list then walks over the active columns of every
// row present in the list. A read shows its result on rsp_data for exactly one cycle
// with rsp_valid, in the first cycle with busy low; it must be captured then, as
// nothing holds it. A clear zeroes the whole memory, whose depth is NODES rounded up
// to a power of two, squared. The same clearing pass runs after reset, so the first
// transaction is taken only once that pass is done. csr writes are taken only
// while the block is idle and no transaction is offered on start.
module weighted_majority_matrix #(
   parameter int unsigned NODES = wmm_pkg::NODES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  wmm_pkg::req_type             req_data,
   output logic                         rsp_valid,
   output wmm_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [wmm_pkg::ACTIVE_W-1:0] csr_data
);
   import wmm_pkg::*;

   localparam int unsigned AddrW = 2 * $clog2(NODES);

   acc_cmd_type        cmd;
   logic [AddrW-1:0]   addr;
   logic [VALUE_W-1:0] rd_value;
   logic               rd_valid;
   logic               sat_hit;
   stat_type           status;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // Node count only changes between transactions
   assign csr_ready = !busy && !start;

   wmm_ctrl #(
      .Nodes (NODES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .addr      (addr),
      .sat_hit   (sat_hit),
      .status    (status)
   );

   wmm_store #(
      .AddrW (AddrW)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .addr     (addr),
      .rd_value (rd_value),
      .rd_valid (rd_valid),
      .sat_hit  (sat_hit)
   );

   // Result register: one-cycle strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rd_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= '{entry_value: rd_value,
                  lists_seen:  status.lists_seen,
                  saturated:   status.saturated};
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while a transaction is still in flight");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(rd_valid))
      else $error("result strobe without a matrix read");

   a_sat_busy: assert property (@(posedge clock) disable iff (reset)
      sat_hit |-> busy)
      else $error("accumulator update outside a transaction");

endmodule
